@@ hdl/assert_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL in this folder.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, muted while the active-low reset is asserted.
`define ASSERT_DIS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ON(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/mma_pkg.sv @@
// -----------------------------------------------------------------------------
// mma_pkg
// Request types and fixed field widths of the multichannel moving average.
// -----------------------------------------------------------------------------
package mma_pkg;

    localparam int CHAN_FIELD_W   = 3;
    localparam int SAMPLE_FIELD_W = 16;

    // input request
    typedef struct packed {
        logic [CHAN_FIELD_W-1:0]          channel;
        logic signed [SAMPLE_FIELD_W-1:0] sample;
        logic                             restart;
    } t_in_req;

    // result request
    typedef struct packed {
        logic [CHAN_FIELD_W-1:0]          channel_out;
        logic signed [SAMPLE_FIELD_W-1:0] mean;
        logic                             window_full;
    } t_out_req;

endpackage

@@ hdl/mma_div.sv @@
// -----------------------------------------------------------------------------
// mma_div
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module mma_div #(
    parameter int SUM_W = 20,
    parameter int DIV_W = 5,
    parameter int Q_W   = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic [Q_W-1:0]          o_quot
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [SUM_W-1:0] r_acc;   // dividend shifts out, quotient shifts in
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_rem;

    logic [DIV_W:0]   w_rem_sh;
    logic [DIV_W:0]   w_rem_sub;
    logic             w_ge;
    logic [DIV_W-1:0] n_rem;
    logic [SUM_W-1:0] w_mag;
    logic [SUM_W-1:0] w_q_sgn;

    always_comb begin
        w_rem_sh  = {r_rem, r_acc[SUM_W-1]};
        w_rem_sub = w_rem_sh - {1'b0, r_div};
        w_ge      = (w_rem_sh >= {1'b0, r_div});
        n_rem     = w_ge ? w_rem_sub[DIV_W-1:0] : w_rem_sh[DIV_W-1:0];
        w_mag     = i_dividend[SUM_W-1] ? (SUM_W'(0) - unsigned'(i_dividend))
                                        : unsigned'(i_dividend);
        w_q_sgn   = r_neg ? (SUM_W'(0) - r_acc) : r_acc;
    end

    assign o_done = r_done;
    assign o_quot = w_q_sgn[Q_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_acc <= w_mag;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_acc <= {r_acc[SUM_W-2:0], w_ge};
        end
    end

    `ASSERT_DIS(a_div_start_idle, i_clk, i_rst_n, i_start |-> !r_busy, "divider restarted while busy")
    `ASSERT_DIS(a_div_done_pulse, i_clk, i_rst_n, o_done |=> !o_done, "divider done longer than one cycle")
    `ASSERT_DIS(a_div_cnt_live, i_clk, i_rst_n, r_busy |-> r_cnt != '0, "divider busy with empty count")

endmodule

@@ hdl/multichannel_moving_average.sv @@
// -----------------------------------------------------------------------------
// multichannel_moving_average
// Per-channel sliding-window mean over the last WINDOW_DEPTH samples.
// -----------------------------------------------------------------------------
// Each input request carries a channel, a signed sample and a restart flag and
// yields exactly one result request: the channel, the mean of the samples now
// in that channel's window (truncated toward zero) and a window_full flag.
// Restart empties the channel before the sample is applied. During warm-up the
// sum is divided by the number of samples seen so far. Samples are taken as
// the low SAMPLE_WIDTH bits of the sample field, sign-extended; the mean is
// returned in the low SAMPLE_WIDTH bits of the mean field. A channel number at
// or above NUM_CHANNELS changes nothing and returns mean 0, window_full 0.
// An in-range request goes through the accept cycle, which reads the channel
// state memory, S_RDST, which reads the window memory, S_UPD, which updates and
// writes back both and starts the serial divider (one quotient bit per cycle),
// and S_DIV, which hands the result to the output register once it is free;
// only then is a new request taken. An out-of-range request goes from accept
// to S_DIV without a divide. The output register decouples the sides: a new
// request is taken while the previous result still waits for the consumer. No
// clearing pass is needed after reset: per-channel valid bits make untouched
// state read as zero, and a window slot is only used once its channel wrote it.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module multichannel_moving_average #(
    parameter int WINDOW_DEPTH = 16,
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mma_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mma_pkg::t_out_req o_out_req
);

    import mma_pkg::*;

    localparam int POS_W    = $clog2(WINDOW_DEPTH);
    localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W    = SAMPLE_WIDTH + POS_W;       // exact sum of a full window
    localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int WIN_ALL  = NUM_CHANNELS * WINDOW_DEPTH;
    localparam int WADDR_W  = $clog2(WIN_ALL);
    localparam int ACALC_W  = CH_W + POS_W;

    // per-channel state word
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [POS_W-1:0]        pos;
        logic [FILL_W-1:0]       fill;
    } t_chan_st;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RDST = 4'b0010,   // channel state out of memory, window read issued
        S_UPD  = 4'b0100,   // old sample back, update and write back, start divide
        S_DIV  = 4'b1000    // divider running, then result to output register
    } t_state;

    // control
    t_state                  r_state, n_state;
    logic [NUM_CHANNELS-1:0] r_st_vld;
    logic                    r_out_valid;
    logic                    r_div_fin;   // quotient ready, waiting for output slot

    // payload
    logic [CHAN_FIELD_W-1:0] r_ch;
    logic [CH_W-1:0]         r_ch_idx;
    logic [SAMPLE_WIDTH-1:0] r_x;
    logic                    r_restart;
    logic                    r_in_range;
    logic signed [SUM_W-1:0] r_sum;
    logic [POS_W-1:0]        r_pos;
    logic [FILL_W-1:0]       r_fill;
    logic                    r_full;
    logic [WADDR_W-1:0]      r_win_addr;
    t_out_req                r_out;

    // memories
    t_chan_st                r_st_mem [NUM_CHANNELS];
    t_chan_st                r_st_rd;
    logic [SAMPLE_WIDTH-1:0] r_win_mem [WIN_ALL];
    logic [SAMPLE_WIDTH-1:0] r_win_rd;

    logic                    w_accept;
    logic                    w_in_range;
    logic [CH_W-1:0]         w_in_idx;
    logic [SAMPLE_WIDTH-1:0] w_x_in;
    t_chan_st                w_st_eff;
    logic [ACALC_W-1:0]      w_addr_calc;
    logic [WADDR_W-1:0]      w_win_addr;
    logic                    w_was_full;
    logic signed [SUM_W-1:0] n_sum;
    logic [FILL_W-1:0]       n_fill;
    logic [POS_W-1:0]        n_pos;
    t_chan_st                w_st_wr;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [SAMPLE_WIDTH-1:0] w_quot;
    logic                    w_slot_free;
    logic                    w_load_out;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_in_range  = (32'(i_in_req.channel) < NUM_CHANNELS);
    assign w_in_idx    = CH_W'(i_in_req.channel);
    // low SAMPLE_WIDTH bits of the field; sign comes from bit SAMPLE_WIDTH-1
    assign w_x_in      = SAMPLE_WIDTH'(unsigned'(i_in_req.sample));

    // restart or a never-touched channel starts from all zeros
    assign w_st_eff    = (r_restart || !r_st_vld[r_ch_idx]) ? '0 : r_st_rd;
    assign w_addr_calc = ACALC_W'(r_ch_idx) * ACALC_W'(WINDOW_DEPTH)
                       + ACALC_W'(w_st_eff.pos);
    assign w_win_addr  = w_addr_calc[WADDR_W-1:0];

    // window update: add new sample, drop the overwritten one once full
    always_comb begin
        w_was_full   = (r_fill == FILL_W'(WINDOW_DEPTH));
        n_sum        = r_sum + SUM_W'(signed'(r_x))
                     - (w_was_full ? SUM_W'(signed'(r_win_rd)) : SUM_W'(0));
        n_fill       = w_was_full ? r_fill : r_fill + 1'b1;
        n_pos        = (r_pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : r_pos + 1'b1;
        w_st_wr.sum  = n_sum;
        w_st_wr.pos  = n_pos;
        w_st_wr.fill = n_fill;
    end

    assign w_div_start = (r_state == S_UPD);

    mma_div #(
        .SUM_W (SUM_W),
        .DIV_W (FILL_W),
        .Q_W   (SAMPLE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_fill),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_slot_free = !r_out_valid || i_out_ready;
    // out-of-range requests skip straight to the output from idle
    assign w_load_out  = (r_state == S_DIV) && (w_div_done || r_div_fin || !r_in_range)
                       && w_slot_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_range ? S_RDST : S_DIV;
                end
            end
            S_RDST:  n_state = S_UPD;
            S_UPD:   n_state = S_DIV;
            S_DIV: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_st_vld    <= '0;
            r_out_valid <= 1'b0;
            r_div_fin   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_load_out || (r_out_valid && !i_out_ready);
            if (w_load_out) begin
                r_div_fin <= 1'b0;
            end else if (w_div_done) begin
                r_div_fin <= 1'b1;
            end
            if (r_state == S_UPD) begin
                r_st_vld[r_ch_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch       <= i_in_req.channel;
            r_ch_idx   <= w_in_idx;
            r_x        <= w_x_in;
            r_restart  <= i_in_req.restart;
            r_in_range <= w_in_range;
        end
        if (r_state == S_RDST) begin
            r_sum      <= w_st_eff.sum;
            r_pos      <= w_st_eff.pos;
            r_fill     <= w_st_eff.fill;
            r_win_addr <= w_win_addr;
        end
        if (r_state == S_UPD) begin
            r_fill <= n_fill;
            r_full <= (n_fill == FILL_W'(WINDOW_DEPTH));
        end
        if (w_load_out) begin
            r_out.channel_out <= r_ch;
            r_out.mean        <= r_in_range ? SAMPLE_FIELD_W'(w_quot) : '0;
            r_out.window_full <= r_in_range && r_full;
        end
    end

    // channel state memory: read on accept, written back in the update cycle
    always_ff @(posedge i_clk) begin
        if (w_accept && w_in_range) begin
            r_st_rd <= r_st_mem[w_in_idx];
        end
        if (r_state == S_UPD) begin
            r_st_mem[r_ch_idx] <= w_st_wr;
        end
    end

    // sample ring memory: oldest slot read, then overwritten with the new sample
    always_ff @(posedge i_clk) begin
        if (r_state == S_RDST) begin
            r_win_rd <= r_win_mem[w_win_addr];
        end
        if (r_state == S_UPD) begin
            r_win_mem[r_win_addr] <= r_x;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    `ASSERT_ON(a_reset_idle, i_clk,
        !i_rst_n |=> (r_state == S_IDLE && !o_out_valid),
        "reset did not idle the block")
    `ASSERT_DIS(a_done_in_div, i_clk, i_rst_n,
        w_div_done |-> r_state == S_DIV,
        "divider finished outside divide state")
    `ASSERT_DIS(a_accept_busy, i_clk, i_rst_n,
        w_accept |=> r_state != S_IDLE,
        "accepted request left no work")
    `ASSERT_DIS(a_fill_bound, i_clk, i_rst_n,
        (r_state == S_DIV && r_in_range) |-> (r_fill != '0 && 32'(r_fill) <= WINDOW_DEPTH),
        "fill count out of range")
    `ASSERT_DIS(a_oor_zero, i_clk, i_rst_n,
        (o_out_valid && 32'(o_out_req.channel_out) >= NUM_CHANNELS)
            |-> (o_out_req.mean == '0 && !o_out_req.window_full),
        "unused channel gave nonzero result")

endmodule
